>>> src/tsct_pkg.sv
// ----------------------------------------------------------------------------
// tsct_pkg
// Shared types, codes and vertex tables for the terrain seam cell tessellator.
// ----------------------------------------------------------------------------
package tsct_pkg;

  // Default limit on the effective grid size
  localparam int GRID_MAX_DEF = 256;
  // Entries in the queue between classifier and emitter
  localparam int QDEPTH       = 2;

  // Chunk kinds on the input word
  localparam logic [3:0] CT_BASE        = 4'd0;
  localparam logic [3:0] CT_LEFT        = 4'd1;
  localparam logic [3:0] CT_RIGHT       = 4'd2;
  localparam logic [3:0] CT_TOP         = 4'd3;
  localparam logic [3:0] CT_BOTTOM      = 4'd4;
  localparam logic [3:0] CT_LEFTTOP     = 4'd5;
  localparam logic [3:0] CT_LEFTBOTTOM  = 4'd6;
  localparam logic [3:0] CT_RIGHTTOP    = 4'd7;
  localparam logic [3:0] CT_RIGHTBOTTOM = 4'd8;

  // Register indexes on the config port
  localparam logic REG_GRID_SIZE = 1'b0;

  // Cell pattern
  typedef enum logic [1:0] {
    KIND_QUAD   = 2'd0,
    KIND_EDGE   = 2'd1,
    KIND_CORNER = 2'd2
  } kind_t;

  // One classified cell, as queued for the emitter
  typedef struct packed {
    logic [3:0] row;   // offset table row (chunk kind code of the pattern)
    kind_t      kind;
    logic [7:0] x;
    logic [7:0] y;
  } cell_t;

  // Index of the final vertex for a pattern
  function automatic logic [3:0] last_index(kind_t kind);
    logic [3:0] n;
    case (kind)
      KIND_EDGE:   n = 4'd8;
      KIND_CORNER: n = 4'd11;
      default:     n = 4'd5;
    endcase
    return n;
  endfunction

  // Triangle list: k-th emitted vertex -> vertex slot of the pattern
  function automatic logic [2:0] tri_vertex(kind_t kind, logic [3:0] k);
    logic [2:0] vi;
    vi = 3'd0;
    case (kind)
      KIND_EDGE: begin
        case (k)
          4'd0: vi = 3'd0;
          4'd1: vi = 3'd1;
          4'd2: vi = 3'd2;
          4'd3: vi = 3'd2;
          4'd4: vi = 3'd1;
          4'd5: vi = 3'd3;
          4'd6: vi = 3'd3;
          4'd7: vi = 3'd4;
          4'd8: vi = 3'd2;
          default: vi = 3'd0;
        endcase
      end
      KIND_CORNER: begin
        case (k)
          4'd0:  vi = 3'd0;
          4'd1:  vi = 3'd1;
          4'd2:  vi = 3'd2;
          4'd3:  vi = 3'd0;
          4'd4:  vi = 3'd3;
          4'd5:  vi = 3'd1;
          4'd6:  vi = 3'd1;
          4'd7:  vi = 3'd4;
          4'd8:  vi = 3'd2;
          4'd9:  vi = 3'd0;
          4'd10: vi = 3'd2;
          4'd11: vi = 3'd5;
          default: vi = 3'd0;
        endcase
      end
      default: begin
        case (k)
          4'd0: vi = 3'd0;
          4'd1: vi = 3'd1;
          4'd2: vi = 3'd2;
          4'd3: vi = 3'd0;
          4'd4: vi = 3'd2;
          4'd5: vi = 3'd3;
          default: vi = 3'd0;
        endcase
      end
    endcase
    return vi;
  endfunction

  // Vertex offset {du, dv} in half cells; one hex digit per slot, slot 0 lowest
  function automatic logic [3:0] vtx_offset(logic [3:0] row, logic [2:0] vi);
    logic [23:0] r;
    case (row)
      CT_LEFT:        r = 24'h0081A2;
      CT_RIGHT:       r = 24'h0A2908;
      CT_TOP:         r = 24'h02068A;
      CT_BOTTOM:      r = 24'h08A420;
      CT_LEFTTOP:     r = 24'hA20618;
      CT_LEFTBOTTOM:  r = 24'h20814A;
      CT_RIGHTTOP:    r = 24'h8A2960;
      CT_RIGHTBOTTOM: r = 24'h08A492;
      default:        r = 24'h008A20;
    endcase
    return r[{vi, 2'b00} +: 4];
  endfunction

endpackage

>>> src/tsct_front.sv
// ----------------------------------------------------------------------------
// tsct_front
// Takes cell words and classifies each as quad, edge stitch or corner stitch.
// ----------------------------------------------------------------------------
module tsct_front #(
  parameter int GRID_MAX = tsct_pkg::GRID_MAX_DEF
) (
  input  logic             start,
  input  logic             full,
  input  logic [8:0]       grid_size,
  input  logic [3:0]       chunk_type,
  input  logic [7:0]       cell_x,
  input  logic [7:0]       cell_y,
  output logic             push,
  output tsct_pkg::cell_t  entry
);

  localparam int GW = $clog2(GRID_MAX + 1);
  localparam int CW = (GW > 9) ? GW : 9;

  logic [CW-1:0] gs_ext;
  logic [CW-1:0] gs;
  logic [CW-1:0] x_ext;
  logic [CW-1:0] y_ext;
  logic          in_grid;
  logic          x0;
  logic          xl;
  logic          y0;
  logic          yt;

  // effective size and boundary flags
  always_comb begin
    gs_ext  = CW'(grid_size);
    gs      = (gs_ext > CW'(GRID_MAX)) ? CW'(GRID_MAX) : gs_ext;
    x_ext   = CW'(cell_x);
    y_ext   = CW'(cell_y);
    in_grid = (x_ext < gs) && (y_ext < gs);
    x0      = (cell_x == 8'd0);
    y0      = (cell_y == 8'd0);
    xl      = ((x_ext + CW'(1)) == gs);
    yt      = ((y_ext + CW'(1)) == gs);
  end

  // classification
  always_comb begin
    entry.row  = tsct_pkg::CT_BASE;
    entry.kind = tsct_pkg::KIND_QUAD;
    entry.x    = cell_x;
    entry.y    = cell_y;
    if (in_grid) begin
      case (chunk_type)
        tsct_pkg::CT_LEFT: begin
          if (x0) begin
            entry.row = tsct_pkg::CT_LEFT; entry.kind = tsct_pkg::KIND_EDGE;
          end
        end
        tsct_pkg::CT_RIGHT: begin
          if (xl) begin
            entry.row = tsct_pkg::CT_RIGHT; entry.kind = tsct_pkg::KIND_EDGE;
          end
        end
        tsct_pkg::CT_TOP: begin
          if (yt) begin
            entry.row = tsct_pkg::CT_TOP; entry.kind = tsct_pkg::KIND_EDGE;
          end
        end
        tsct_pkg::CT_BOTTOM: begin
          if (y0) begin
            entry.row = tsct_pkg::CT_BOTTOM; entry.kind = tsct_pkg::KIND_EDGE;
          end
        end
        tsct_pkg::CT_LEFTTOP: begin
          if (x0 && yt) begin
            entry.row = tsct_pkg::CT_LEFTTOP; entry.kind = tsct_pkg::KIND_CORNER;
          end else if (x0) begin
            entry.row = tsct_pkg::CT_LEFT; entry.kind = tsct_pkg::KIND_EDGE;
          end else if (yt) begin
            entry.row = tsct_pkg::CT_TOP; entry.kind = tsct_pkg::KIND_EDGE;
          end
        end
        tsct_pkg::CT_LEFTBOTTOM: begin
          if (x0 && y0) begin
            entry.row = tsct_pkg::CT_LEFTBOTTOM; entry.kind = tsct_pkg::KIND_CORNER;
          end else if (x0) begin
            entry.row = tsct_pkg::CT_LEFT; entry.kind = tsct_pkg::KIND_EDGE;
          end else if (y0) begin
            entry.row = tsct_pkg::CT_BOTTOM; entry.kind = tsct_pkg::KIND_EDGE;
          end
        end
        tsct_pkg::CT_RIGHTTOP: begin
          if (xl && yt) begin
            entry.row = tsct_pkg::CT_RIGHTTOP; entry.kind = tsct_pkg::KIND_CORNER;
          end else if (xl) begin
            entry.row = tsct_pkg::CT_RIGHT; entry.kind = tsct_pkg::KIND_EDGE;
          end else if (yt) begin
            entry.row = tsct_pkg::CT_TOP; entry.kind = tsct_pkg::KIND_EDGE;
          end
        end
        tsct_pkg::CT_RIGHTBOTTOM: begin
          if (xl && y0) begin
            entry.row = tsct_pkg::CT_RIGHTBOTTOM; entry.kind = tsct_pkg::KIND_CORNER;
          end else if (xl) begin
            entry.row = tsct_pkg::CT_RIGHT; entry.kind = tsct_pkg::KIND_EDGE;
          end else if (y0) begin
            entry.row = tsct_pkg::CT_BOTTOM; entry.kind = tsct_pkg::KIND_EDGE;
          end
        end
        default: begin
          entry.row  = tsct_pkg::CT_BASE;
          entry.kind = tsct_pkg::KIND_QUAD;
        end
      endcase
    end
  end

  // word accepted whenever the queue has room
  assign push = start && !full;

endmodule

>>> src/tsct_queue.sv
// ----------------------------------------------------------------------------
// tsct_queue
// Short FIFO of classified cells between the classifier and the emitter.
// ----------------------------------------------------------------------------
module tsct_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  tsct_pkg::cell_t  din,
  input  logic             pop,
  output tsct_pkg::cell_t  dout,
  output logic             full,
  output logic             empty
);

  localparam int PW = (tsct_pkg::QDEPTH > 1) ? $clog2(tsct_pkg::QDEPTH) : 1;
  localparam int NW = $clog2(tsct_pkg::QDEPTH + 1);

  tsct_pkg::cell_t slots [tsct_pkg::QDEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [NW-1:0]   count;

  assign full  = (count == NW'(tsct_pkg::QDEPTH));
  assign empty = (count == '0);
  assign dout  = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(tsct_pkg::QDEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(tsct_pkg::QDEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + NW'(1);
      end else if (pop && !push) begin
        count <= count - NW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("queue read while empty");

endmodule

>>> src/tsct_back.sv
// ----------------------------------------------------------------------------
// tsct_back
// Vertex emitter: walks the triangle list of one cell, one vertex per cycle.
// ----------------------------------------------------------------------------
module tsct_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             empty,
  input  tsct_pkg::cell_t  head,
  output logic             pop,
  output logic             strobe,
  output logic [9:0]       vertex_u,
  output logic [9:0]       vertex_v,
  output logic [1:0]       piece_kind,
  output logic             last_vertex
);

  tsct_pkg::cell_t cur;
  logic            act;
  logic [3:0]      cnt;
  logic            at_last;
  logic [2:0]      vi;
  logic [3:0]      off;

  // vertex lookup for the current step
  always_comb begin
    at_last = act && (cnt == tsct_pkg::last_index(cur.kind));
    pop     = !empty && (!act || at_last);
    vi      = tsct_pkg::tri_vertex(cur.kind, cnt);
    off     = tsct_pkg::vtx_offset(cur.row, vi);
  end

  // step control: next cell loads right after the final vertex
  always_ff @(posedge clk) begin
    if (rst) begin
      act    <= 1'b0;
      cnt    <= '0;
      strobe <= 1'b0;
    end else begin
      strobe <= act;
      if (pop) begin
        act <= 1'b1;
        cnt <= '0;
      end else if (at_last) begin
        act <= 1'b0;
      end else if (act) begin
        cnt <= cnt + 4'd1;
      end
    end
  end

  // current cell
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (act) begin
      vertex_u    <= {1'b0, cur.x, 1'b0} + {8'd0, off[3:2]};
      vertex_v    <= {1'b0, cur.y, 1'b0} + {8'd0, off[1:0]};
      piece_kind  <= cur.kind;
      last_vertex <= at_last;
    end
  end

  a_step_emits: assert property (@(posedge clk) disable iff (rst) act |=> strobe)
    else $error("active step produced no result word");
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
      act |-> (cnt <= tsct_pkg::last_index(cur.kind)))
    else $error("vertex counter past end of triangle list");

endmodule

>>> src/terrain_seam_cell_tessellator_core.sv
// ----------------------------------------------------------------------------
// terrain_seam_cell_tessellator_core
// Cell tessellator with seam stitching for square terrain chunks.
// ----------------------------------------------------------------------------
// A cell word is taken when start is high and busy is low. Each cell yields
// 6 (quad), 9 (edge stitch) or 12 (corner stitch) result words, one per clock
// on strobe, the last one flagged by last_vertex, all from the single vertex
// emitter. A taken cell goes through the queue slot and the emitter's current
// cell register to the result word register when the emitter is free. A
// two-entry queue sits between classifier and emitter, so new cells are taken
// while results stream; busy rises only when that queue is full. The receiver
// cannot stall: every result word is valid for exactly one cycle. Coordinates
// are in half-cell units; the user must write grid_size over the APB port only
// while no cell is in flight, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module terrain_seam_cell_tessellator_core #(
  parameter int GRID_MAX = tsct_pkg::GRID_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // cell input
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  chunk_type,
  input  logic [7:0]  cell_x,
  input  logic [7:0]  cell_y,
  // vertex output
  output logic        strobe,
  output logic [9:0]  vertex_u,
  output logic [9:0]  vertex_v,
  output logic [1:0]  piece_kind,
  output logic        last_vertex,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [8:0]      grid_size;
  logic            push;
  logic            pop;
  logic            q_full;
  logic            q_empty;
  tsct_pkg::cell_t entry;
  tsct_pkg::cell_t head;

  // config register
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size <= 9'd1;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == tsct_pkg::REG_GRID_SIZE)) begin
      grid_size <= pwdata[8:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == tsct_pkg::REG_GRID_SIZE) begin
      prdata = {23'd0, grid_size};
    end
  end

  assign busy = q_full;

  tsct_front #(
    .GRID_MAX (GRID_MAX)
  ) u_front (
    .start      (start),
    .full       (q_full),
    .grid_size  (grid_size),
    .chunk_type (chunk_type),
    .cell_x     (cell_x),
    .cell_y     (cell_y),
    .push       (push),
    .entry      (entry)
  );

  tsct_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (entry),
    .pop   (pop),
    .dout  (head),
    .full  (q_full),
    .empty (q_empty)
  );

  tsct_back u_back (
    .clk         (clk),
    .rst         (rst),
    .empty       (q_empty),
    .head        (head),
    .pop         (pop),
    .strobe      (strobe),
    .vertex_u    (vertex_u),
    .vertex_v    (vertex_v),
    .piece_kind  (piece_kind),
    .last_vertex (last_vertex)
  );

endmodule
